@@ rtl/ilid_pkg.sv @@
// Package: shared constants, codes and types for the indexed list block.
package ilid_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 7;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int VAL_W    = 32;
    localparam int CMD_W    = 3;
    localparam int STAT_W   = 2;
    localparam int ECNT_W   = 7;

    localparam logic signed [VAL_W-1:0] NO_VALUE = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ     = 3'd0,
        CMD_INS_HEAD = 3'd1,
        CMD_INS_TAIL = 3'd2,
        CMD_INS_AT   = 3'd3,
        CMD_DELETE   = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE   = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2
    } cell_op_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        cell_op_t                 op;
        logic [CMP_W-1:0]         pos;
        logic [CMP_W-1:0]         cnt;
        logic signed [VAL_W-1:0]  value;
    } cell_ctl_t;

endpackage

@@ rtl/ilid_if.sv @@
// Interfaces: command channel and result channel with valid/ready handshake.
interface ilid_req_if;
    logic                                   valid;
    logic                                   ready;
    logic [ilid_pkg::CMD_W-1:0]             cmd;
    logic [ilid_pkg::POS_W-1:0]             position;
    logic signed [ilid_pkg::VAL_W-1:0]      new_value;

    modport source (output valid, output cmd, output position, output new_value, input ready);
    modport sink   (input valid, input cmd, input position, input new_value, output ready);
endinterface

interface ilid_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ilid_pkg::VAL_W-1:0]      read_value;
    logic [ilid_pkg::STAT_W-1:0]            status;
    logic [ilid_pkg::ECNT_W-1:0]            entry_count;

    modport source (output valid, output read_value, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input read_value, input status, input entry_count,
                    output ready);
endinterface

@@ rtl/indexed_list_insert_delete.sv @@
// Top level: indexed list of signed values held in a chain of shifting cells.
//
// The block keeps an ordered list of up to ilid_pkg::CAPACITY signed 32-bit
// values in a row of cells, position 0 in the first cell. Each command item
// on req (read, insert at head, insert at tail, insert before a position,
// delete at a position) yields exactly one result item on rsp carrying the
// value read (-1 unless a successful read), a status (done, position invalid,
// list full) and the entry count after the command. Inserts and deletes move
// every affected cell by one slot in the same clock, and a read selects a
// cell through an AND-OR tree, so a new item is accepted every cycle while
// rsp takes results, and a result that waits in the output register holds
// off the next item until rsp takes it. Cells power up undefined; only
// positions below the count are ever read. No clearing pass.
module indexed_list_insert_delete (
    input  logic              clk,
    input  logic              rst_n,
    ilid_req_if.sink          req,
    ilid_rsp_if.source        rsp
);

    localparam int CAP   = ilid_pkg::CAPACITY;
    localparam int CNT_W = ilid_pkg::CNT_W;
    localparam int CMP_W = ilid_pkg::CMP_W;
    localparam int VAL_W = ilid_pkg::VAL_W;

    logic [CNT_W-1:0]                 count_reg;
    logic [CNT_W-1:0]                 count_next;
    logic                             rsp_valid_reg;
    logic signed [VAL_W-1:0]          read_value_reg;
    logic [ilid_pkg::STAT_W-1:0]      status_reg;
    logic [ilid_pkg::ECNT_W-1:0]      entry_count_reg;

    logic                             accept;
    logic [CMP_W-1:0]                 cnt_ext;
    logic [CMP_W-1:0]                 pos_ext;
    logic [CMP_W-1:0]                 ins_pos;
    logic                             is_insert;
    ilid_pkg::cell_ctl_t              ctl;
    ilid_pkg::status_t                status_c;
    logic signed [VAL_W-1:0]          read_value_c;
    logic signed [VAL_W-1:0]          sel_val;
    logic signed [VAL_W-1:0]          cell_val  [CAP];
    logic signed [VAL_W-1:0]          left_val  [CAP];
    logic signed [VAL_W-1:0]          right_val [CAP];

    // Accept while the output register is empty or being drained.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign cnt_ext = CMP_W'(count_reg);
    assign pos_ext = CMP_W'(req.position);

    // AND-OR select of the addressed cell for reads.
    always_comb
    begin
        sel_val = '0;
        for (int i = 0; i < CAP; i++)
        begin
            if (CMP_W'(i) == pos_ext)
                sel_val = sel_val | cell_val[i];
        end
    end

    // Decode the command, pick the insert position, form status and count.
    always_comb
    begin
        is_insert    = 1'b0;
        ins_pos      = pos_ext;
        status_c     = ilid_pkg::ST_BADPOS;
        read_value_c = ilid_pkg::NO_VALUE;
        count_next   = count_reg;
        ctl.op       = ilid_pkg::OP_HOLD;
        ctl.pos      = pos_ext;
        ctl.cnt      = cnt_ext;
        ctl.value    = req.new_value;

        unique case (req.cmd)
            ilid_pkg::CMD_READ:
            begin
                if (pos_ext < cnt_ext)
                begin
                    read_value_c = sel_val;
                    status_c     = ilid_pkg::ST_DONE;
                end
            end
            ilid_pkg::CMD_INS_HEAD:
            begin
                is_insert = 1'b1;
                ins_pos   = '0;
            end
            ilid_pkg::CMD_INS_TAIL:
            begin
                is_insert = 1'b1;
                ins_pos   = cnt_ext;
            end
            ilid_pkg::CMD_INS_AT:
            begin
                is_insert = 1'b1;
                ins_pos   = pos_ext;
            end
            ilid_pkg::CMD_DELETE:
            begin
                if (pos_ext < cnt_ext)
                begin
                    status_c   = ilid_pkg::ST_DONE;
                    count_next = count_reg - CNT_W'(1);
                    if (accept)
                        ctl.op = ilid_pkg::OP_DELETE;
                end
            end
            default:
            begin
                status_c = ilid_pkg::ST_BADPOS;
            end
        endcase

        if (is_insert)
        begin
            ctl.pos = ins_pos;
            // a bad position wins over a full list
            priority if (ins_pos > cnt_ext)
                status_c = ilid_pkg::ST_BADPOS;
            else if (count_reg >= CNT_W'(CAP))
                status_c = ilid_pkg::ST_FULL;
            else
            begin
                status_c   = ilid_pkg::ST_DONE;
                count_next = count_reg + CNT_W'(1);
                if (accept)
                    ctl.op = ilid_pkg::OP_INSERT;
            end
        end
    end

    // Chain of cells: each sees its neighbors on both sides.
    for (genvar g = 0; g < CAP; g++)
    begin : g_cell
        if (g == 0)
        begin : g_first
            assign left_val[g] = req.new_value;
        end
        else
        begin : g_left
            assign left_val[g] = cell_val[g-1];
        end

        if (g == CAP - 1)
        begin : g_last
            assign right_val[g] = '0;
        end
        else
        begin : g_right
            assign right_val[g] = cell_val[g+1];
        end

        ilid_cell u_cell (
            .clk       (clk),
            .index     (CMP_W'(g)),
            .ctl       (ctl),
            .left_val  (left_val[g]),
            .right_val (right_val[g]),
            .val       (cell_val[g])
        );
    end

    // Control state: count and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load on accept, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_value_reg  <= read_value_c;
            status_reg      <= status_c;
            entry_count_reg <= ilid_pkg::ECNT_W'(count_next);
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.read_value  = read_value_reg;
    assign rsp.status      = status_reg;
    assign rsp.entry_count = entry_count_reg;

endmodule

@@ rtl/ilid_cell.sv @@
// Cell: one list slot; loads, takes its left or right neighbor, or holds.
module ilid_cell (
    input  logic                               clk,
    input  logic [ilid_pkg::CMP_W-1:0]         index,
    input  ilid_pkg::cell_ctl_t                ctl,
    input  logic signed [ilid_pkg::VAL_W-1:0]  left_val,
    input  logic signed [ilid_pkg::VAL_W-1:0]  right_val,
    output logic signed [ilid_pkg::VAL_W-1:0]  val
);

    logic signed [ilid_pkg::VAL_W-1:0] val_reg;
    logic signed [ilid_pkg::VAL_W-1:0] val_next;
    logic [ilid_pkg::CMP_W:0]          index_plus;

    assign index_plus = {1'b0, index} + {{ilid_pkg::CMP_W{1'b0}}, 1'b1};

    always_comb
    begin
        val_next = val_reg;
        unique case (ctl.op)
            ilid_pkg::OP_INSERT:
            begin
                if (index == ctl.pos)
                    val_next = ctl.value;
                else if (index > ctl.pos && index <= ctl.cnt)
                    val_next = left_val;
            end
            ilid_pkg::OP_DELETE:
            begin
                // pull from the right over the deleted slot
                if (index >= ctl.pos && index_plus < {1'b0, ctl.cnt})
                    val_next = right_val;
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

@@ rtl/ilid_checker.sv @@
// Checker: port-level properties of the indexed list block, and its bind.
module ilid_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               rsp_valid,
    input  logic                               rsp_ready,
    input  logic signed [ilid_pkg::VAL_W-1:0]  read_value,
    input  logic [ilid_pkg::STAT_W-1:0]        status,
    input  logic [ilid_pkg::ECNT_W-1:0]        entry_count
);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> entry_count <= ilid_pkg::ECNT_W'(ilid_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status == ilid_pkg::ST_DONE || status == ilid_pkg::ST_BADPOS
                       || status == ilid_pkg::ST_FULL))
        else $error("undefined status code");

    a_fail_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ilid_pkg::ST_DONE |-> read_value == ilid_pkg::NO_VALUE)
        else $error("failed command carries a value");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ilid_pkg::ST_FULL
            |-> entry_count == ilid_pkg::ECNT_W'(ilid_pkg::CAPACITY))
        else $error("full status without a full list");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result item dropped while stalled");

endmodule

bind indexed_list_insert_delete ilid_checker u_ilid_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .read_value  (rsp.read_value),
    .status      (rsp.status),
    .entry_count (rsp.entry_count)
);
